@@ src/m3inv_pkg.sv @@
// shared types, constants and arithmetic helpers for the 3x3 inverse block
`default_nettype none
package m3inv_pkg;

    localparam int DW      = 32;
    localparam int FB      = 16;
    localparam int CW      = 2 * DW + 1;     // cofactor width
    localparam int DETW    = 3 * DW + 3;     // determinant width
    localparam int MAGW    = DETW;           // determinant magnitude width
    localparam int NUMW    = CW + 2 * FB;    // shifted numerator magnitude width
    localparam int QW      = DW + 1;         // quotient bits kept (rest only flag overflow)
    localparam int THRW    = 31;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam int NDIV    = 9;

    // one classified item moving from front to back
    typedef struct packed {
        logic                   singular;
        logic [MAGW-1:0]        dmag;
        logic                   dneg;
        logic [8:0][CW-1:0]     adj;
    } job_t;

    // one result item
    typedef struct packed {
        logic                   saturated;
        logic                   singular;
        logic [8:0][DW-1:0]     b;
    } res_t;

endpackage
`default_nettype wire

@@ src/matrix3x3_inverse_top.sv @@
// top level of the 3x3 matrix inverse block
//  channel | dir | handshake            | payload
//  s_axis  | in  | tvalid/tready        | tdata a00..a22
//  m_axis  | out | tvalid/tready        | tdata b00..b22, tuser singular,saturated
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_data singular_threshold
// one item per cycle sustained while m_axis_tready stays high; an item passes
// five front stages, the queue, 98 divider stages and the result register
// on its way from input to output. reset clears all valid state and sets the
// threshold to 1. m_axis_tready low freezes the back pipeline; a queue of four
// items lets the front keep taking items until it fills, then s_axis_tready drops.
`default_nettype none
module matrix3x3_inverse_top
    import m3inv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [9*DW-1:0]    s_axis_tdata,   // a00,a01,...,a22
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [9*DW-1:0]         m_axis_tdata,   // b00,b01,...,b22
    output logic [1:0]              m_axis_tuser,   // singular, saturated
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [THRW-1:0]    cfg_data        // singular_threshold
);

    logic [THRW-1:0] thr_reg;
    logic            f_valid, f_ready, b_valid, b_ready;
    job_t            f_job, b_job;
    res_t            res;

    assign cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRW'(1);
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    m3inv_front u_front (
        .clk (clk), .rst_n (rst_n),
        .in_valid (s_axis_tvalid), .in_ready (s_axis_tready), .in_data (s_axis_tdata),
        .thr (thr_reg),
        .out_valid (f_valid), .out_ready (f_ready), .out_job (f_job)
    );

    m3inv_fifo u_fifo (
        .clk (clk), .rst_n (rst_n),
        .wr_valid (f_valid), .wr_ready (f_ready), .wr_job (f_job),
        .rd_valid (b_valid), .rd_ready (b_ready), .rd_job (b_job)
    );

    m3inv_back u_back (
        .clk (clk), .rst_n (rst_n),
        .in_valid (b_valid), .in_ready (b_ready), .in_job (b_job),
        .out_valid (m_axis_tvalid), .out_ready (m_axis_tready), .out_res (res)
    );

    assign m_axis_tdata = res.b;
    assign m_axis_tuser = {res.saturated, res.singular};

endmodule
`default_nettype wire

@@ src/m3inv_front.sv @@
// front part: cofactors, determinant and singular test over five stages
`default_nettype none
module m3inv_front
    import m3inv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [9*DW-1:0]   in_data,
    input  wire logic [THRW-1:0]   thr,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output job_t                   out_job
);

    logic signed [DW-1:0] a [9];
    logic [4:0]           v_reg;
    logic                 adv;

    // stage data
    logic signed [DW-1:0]   a_reg [9];
    logic signed [CW-1:0]   c_reg [9];
    logic signed [DW-1:0]   r0_reg [3];
    logic signed [2*DW:0]   plo_reg [3];
    logic signed [2*DW:0]   phi_reg [3];
    logic signed [CW-1:0]   c3_reg [9];
    logic signed [DETW-1:0] det_reg;
    logic signed [CW-1:0]   c4_reg [9];
    job_t                   j_reg;

    logic [MAGW-1:0]        dmag;
    logic [MAGW-1:0]        thr_sh;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            a[i] = in_data[i*DW +: DW];
    end

    // pipeline moves as a whole when its tail can leave
    assign adv       = !v_reg[4] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[4];
    assign out_job   = j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[3:0], in_valid};
    end

    // determinant magnitude and threshold
    assign dmag   = det_reg[DETW-1] ? MAGW'(-det_reg) : MAGW'(det_reg);
    assign thr_sh = MAGW'(thr) << (2 * FB);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: capture the matrix
            for (int i = 0; i < 9; i++)
                a_reg[i] <= a[i];
            // stage 2: cofactors, first row kept for the expansion
            c_reg[0] <= CW'(a_reg[4] * a_reg[8]) - CW'(a_reg[5] * a_reg[7]);
            c_reg[1] <= CW'(a_reg[2] * a_reg[7]) - CW'(a_reg[1] * a_reg[8]);
            c_reg[2] <= CW'(a_reg[1] * a_reg[5]) - CW'(a_reg[2] * a_reg[4]);
            c_reg[3] <= CW'(a_reg[5] * a_reg[6]) - CW'(a_reg[3] * a_reg[8]);
            c_reg[4] <= CW'(a_reg[0] * a_reg[8]) - CW'(a_reg[2] * a_reg[6]);
            c_reg[5] <= CW'(a_reg[2] * a_reg[3]) - CW'(a_reg[0] * a_reg[5]);
            c_reg[6] <= CW'(a_reg[3] * a_reg[7]) - CW'(a_reg[4] * a_reg[6]);
            c_reg[7] <= CW'(a_reg[1] * a_reg[6]) - CW'(a_reg[0] * a_reg[7]);
            c_reg[8] <= CW'(a_reg[0] * a_reg[4]) - CW'(a_reg[1] * a_reg[3]);
            for (int i = 0; i < 3; i++)
                r0_reg[i] <= a_reg[i];
            // stage 3: expansion products split into low and high cofactor halves
            for (int i = 0; i < 3; i++)
            begin
                plo_reg[i] <= (2*DW+1)'(r0_reg[i])
                              * (2*DW+1)'($signed({1'b0, c_reg[3*i][DW-1:0]}));
                phi_reg[i] <= (2*DW+1)'(r0_reg[i])
                              * (2*DW+1)'($signed(c_reg[3*i][CW-1:DW]));
            end
            for (int i = 0; i < 9; i++)
                c3_reg[i] <= c_reg[i];
            // stage 4: determinant
            det_reg <= (DETW'(phi_reg[0]) << DW) + DETW'(plo_reg[0])
                     + (DETW'(phi_reg[1]) << DW) + DETW'(plo_reg[1])
                     + (DETW'(phi_reg[2]) << DW) + DETW'(plo_reg[2]);
            for (int i = 0; i < 9; i++)
                c4_reg[i] <= c3_reg[i];
            // stage 5: classify
            for (int i = 0; i < 9; i++)
                j_reg.adj[i] <= c4_reg[i];
            j_reg.dmag     <= dmag;
            j_reg.dneg     <= det_reg[DETW-1];
            j_reg.singular <= (dmag <= thr_sh);
        end
    end

endmodule
`default_nettype wire

@@ src/m3inv_fifo.sv @@
// short queue of classified items between front and back
`default_nettype none
module m3inv_fifo
    import m3inv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire job_t  wr_job,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output job_t       rd_job
);

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           wr, rd;

    assign wr_ready = (cnt_reg != QDEPTH[QAW:0]);
    assign rd_valid = (cnt_reg != '0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(wr) - (QAW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_job;
    end

endmodule
`default_nettype wire

@@ src/m3inv_div.sv @@
// pipelined restoring divider, one quotient bit per stage, sign and saturation at the end
`default_nettype none
module m3inv_div
    import m3inv_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            adv,
    input  wire logic [CW-1:0]   num_in,
    input  wire logic            neg_in,
    input  wire logic [MAGW-1:0] den_in,
    output logic [DW-1:0]        q_out,
    output logic                 sat_out
);

    // numerator magnitude shifted up by 2*FB; quotient bits above QW only flag overflow
    localparam int NS = NUMW;

    logic [NS-1:0]   n_reg   [NS+1];
    logic [MAGW:0]   r_reg   [NS+1];
    logic [QW-1:0]   q_reg   [NS+1];
    logic            big_reg [NS+1];
    logic            neg_reg [NS+1];
    logic [MAGW-1:0] d_reg   [NS+1];
    logic [CW-1:0]   mag;
    logic [DW:0]     lim;

    assign mag = num_in[CW-1] ? CW'(-num_in) : num_in;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]   <= {mag, (2*FB)'(0)};
            r_reg[0]   <= '0;
            q_reg[0]   <= '0;
            big_reg[0] <= 1'b0;
            neg_reg[0] <= neg_in;
            d_reg[0]   <= den_in;
            for (int s = 0; s < NS; s++)
            begin : g
                logic [MAGW:0] t;
                logic          ge;
                t  = {r_reg[s][MAGW-1:0], n_reg[s][NS-1]};
                ge = (t >= {1'b0, d_reg[s]});
                r_reg[s+1]   <= ge ? t - {1'b0, d_reg[s]} : t;
                n_reg[s+1]   <= n_reg[s] << 1;
                q_reg[s+1]   <= {q_reg[s][QW-2:0], ge};
                big_reg[s+1] <= big_reg[s] | (ge & q_reg[s][QW-1]) | q_reg[s][QW-1];
                neg_reg[s+1] <= neg_reg[s];
                d_reg[s+1]   <= d_reg[s];
            end
        end
    end

    // clamp and apply sign
    always_comb
    begin
        lim     = {1'b0, {DW{1'b1}}} >> 1;
        if (neg_reg[NS]) lim = lim + 1'b1;
        sat_out = big_reg[NS] || ({1'b0, q_reg[NS][QW-2:0]} > lim)
                  || q_reg[NS][QW-1];
        if (sat_out)
            q_out = neg_reg[NS] ? DW'(-lim) : lim[DW-1:0];
        else
            q_out = neg_reg[NS] ? DW'(-q_reg[NS][DW-1:0]) : q_reg[NS][DW-1:0];
    end

endmodule
`default_nettype wire

@@ src/m3inv_back.sv @@
// back part: nine pipelined dividers with a result register
`default_nettype none
module m3inv_back
    import m3inv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire job_t  in_job,
    output logic       out_valid,
    input  wire logic  out_ready,
    output res_t       out_res
);

    // divider stages plus the result register
    localparam int LAT = NUMW + 2;

    logic [LAT-1:0] v_reg;
    logic [LAT-2:0] s_reg;
    logic           adv;
    logic [DW-1:0]  q [9];
    logic [8:0]     sat;
    res_t           r;

    assign adv       = !v_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv) s_reg <= {s_reg[LAT-3:0], in_job.singular};
    end

    // one divider per entry, all advancing together
    for (genvar k = 0; k < 9; k++)
    begin : g_div
        m3inv_div u_div (
            .clk     (clk),
            .adv     (adv),
            .num_in  (in_job.adj[k]),
            .neg_in  (in_job.adj[k][CW-1] ^ in_job.dneg),
            .den_in  (in_job.singular ? MAGW'(1) : in_job.dmag),
            .q_out   (q[k]),
            .sat_out (sat[k])
        );
    end

    always_comb
    begin
        r.singular  = s_reg[LAT-2];
        r.saturated = !s_reg[LAT-2] && (|sat);
        for (int k = 0; k < 9; k++)
            r.b[k] = s_reg[LAT-2] ? '0 : q[k];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv) out_res <= r;
    end

endmodule
`default_nettype wire

@@ src/m3inv_checker.sv @@
// port-level checks for the 3x3 inverse block, bound to the top level
`default_nettype none
module m3inv_checker
    import m3inv_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            m_axis_tvalid,
    input wire logic            m_axis_tready,
    input wire logic [9*DW-1:0] m_axis_tdata,
    input wire logic [1:0]      m_axis_tuser
);

    // singular results carry zero entries
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("singular result with nonzero entries");

    // flags never both set
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("singular and saturated together");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind matrix3x3_inverse_top m3inv_checker u_checker (
    .clk (clk), .rst_n (rst_n),
    .m_axis_tvalid (m_axis_tvalid), .m_axis_tready (m_axis_tready),
    .m_axis_tdata (m_axis_tdata), .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire

@@ tb/sv/matrix3x3_inverse_top_test.sv @@
// testbench for the 3x3 matrix inverse block: exact-arithmetic predictor and scoreboard
`default_nettype none
module matrix3x3_inverse_top_test
    import m3inv_pkg::*;
();

    localparam int  N_RANDOM    = 400;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  DRAIN_WAIT  = 150;
    localparam int  HOLD_CYCLES = 300;
    localparam logic [DW-1:0] ONE = 32'h0001_0000;
    localparam logic [DW-1:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] MINV = 32'h8000_0000;

    // matrix kinds for random stimulus
    typedef enum int {
        KIND_SMALL, KIND_FULL, KIND_DEPENDENT, KIND_DOMINANT, KIND_TINY
    } mat_kind_e;

    // scoreboard: exact inverse prediction and in-order comparison
    class inverse_board;
        res_t            pending[$];
        logic [THRW-1:0] threshold;
        int              failures;
        int              n_results;
        int              n_singular;
        int              n_saturated;

        function void set_threshold(logic [THRW-1:0] v);
            threshold = v;
        endfunction

        function res_t invert(logic [9*DW-1:0] d);
            logic signed [255:0] a [9];
            logic signed [255:0] adj [9];
            logic signed [255:0] det;
            logic [255:0]        mag;
            logic [255:0]        limit_w;
            logic [255:0]        num;
            logic [255:0]        q;
            logic [255:0]        lim;
            logic                neg;
            res_t                r;
            int                  pick [9][4];
            pick = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
                     '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
                     '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
            r = '0;
            for (int i = 0; i < 9; i++)
                a[i] = $signed(d[i*DW +: DW]);
            for (int i = 0; i < 9; i++)
                adj[i] = a[pick[i][0]] * a[pick[i][1]] - a[pick[i][2]] * a[pick[i][3]];
            det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
            mag = (det < 0) ? -det : det;
            limit_w = 256'(threshold) << (2 * FB);
            // determinant within threshold counts as singular
            if (mag <= limit_w)
            begin
                r.singular = 1'b1;
                return r;
            end
            for (int k = 0; k < 9; k++)
            begin
                neg = (adj[k] < 0) != (det < 0);
                num = ((adj[k] < 0) ? -adj[k] : adj[k]) << (2 * FB);
                q = num / mag;
                lim = neg ? (256'd1 << (DW - 1)) : ((256'd1 << (DW - 1)) - 1);
                if (q > lim)
                begin
                    q = lim;
                    r.saturated = 1'b1;
                end
                r.b[k] = neg ? -q[DW-1:0] : q[DW-1:0];
            end
            return r;
        endfunction

        function void note_matrix(logic [9*DW-1:0] d);
            pending.push_back(invert(d));
        endfunction

        function void check_result(logic [9*DW-1:0] d, logic [1:0] u);
            res_t want;
            if (pending.size() == 0)
            begin
                $error("result item with nothing expected");
                failures++;
                return;
            end
            want = pending.pop_front();
            n_results++;
            if (want.singular) n_singular++;
            if (want.saturated) n_saturated++;
            for (int k = 0; k < 9; k++)
                if (d[k*DW +: DW] !== want.b[k])
                begin
                    $error("b%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                           $signed(want.b[k]), $signed(d[k*DW +: DW]));
                    failures++;
                end
            if (u[0] !== want.singular)
            begin
                $error("singular: expected %0b, got %0b", want.singular, u[0]);
                failures++;
            end
            if (u[1] !== want.saturated)
            begin
                $error("saturated: expected %0b, got %0b", want.saturated, u[1]);
                failures++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [9*DW-1:0] s_axis_tdata;     // a00,a01,...,a22
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [9*DW-1:0] m_axis_tdata;     // b00,b01,...,b22
    logic [1:0]      m_axis_tuser;     // singular, saturated
    logic            cfg_valid;
    logic            cfg_ready;
    logic [THRW-1:0] cfg_data;

    inverse_board board;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    int           cycles;
    int           n_sent;

    matrix3x3_inverse_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver readiness, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // accepted items on both sides
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            board.note_matrix(s_axis_tdata);
            n_sent++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d items outstanding", board.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_matrix(logic [9*DW-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_threshold(logic [THRW-1:0] v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_threshold(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait for every expected item, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic [9*DW-1:0] make_matrix(mat_kind_e kind);
        logic [DW-1:0] e [9];
        for (int i = 0; i < 9; i++)
        begin
            case (kind)
                KIND_SMALL:    e[i] = $signed($urandom_range(524288)) - 262144;
                KIND_FULL:     e[i] = $urandom;
                KIND_TINY:     e[i] = $signed($urandom_range(511)) - 256;
                KIND_DOMINANT: e[i] = (i % 4 == 0)
                                      ? ($urandom_range(1) ? 32'sd1 : -32'sd1)
                                        * $signed($urandom_range(32'h0100_0000, 32'h0004_0000))
                                      : $signed($urandom_range(131072)) - 65536;
                default:       e[i] = $signed($urandom_range(65536)) - 32768;
            endcase
        end
        // third row as sum of the first two: singular or nearly so
        if (kind == KIND_DEPENDENT)
            for (int c = 0; c < 3; c++)
                e[6 + c] = e[c] + e[3 + c] + (($urandom_range(3) == 0) ? $urandom_range(2) : 0);
        return {e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};
    endfunction

    task automatic random_items(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 35)      send_matrix(make_matrix(KIND_SMALL));
            else if (r < 55) send_matrix(make_matrix(KIND_DOMINANT));
            else if (r < 70) send_matrix(make_matrix(KIND_DEPENDENT));
            else if (r < 85) send_matrix(make_matrix(KIND_FULL));
            else             send_matrix(make_matrix(KIND_TINY));
        end
    endtask

    function automatic logic [9*DW-1:0] diag3(logic [DW-1:0] x, logic [DW-1:0] y,
                                                logic [DW-1:0] z);
        return {x, 32'd0, 32'd0, 32'd0, y, 32'd0, 32'd0, 32'd0, z};
    endfunction

    initial
    begin
        board = new();
        board.set_threshold(31'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        cycles         = 0;
        n_sent         = 0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: identity, zero, extremes, sign mixes, saturation
        send_matrix(diag3(ONE, ONE, ONE));
        send_matrix('0);
        send_matrix({9{MAXV}});
        send_matrix({9{MINV}});
        send_matrix(diag3(MAXV, MAXV, MAXV));
        send_matrix(diag3(MINV, MINV, MINV));
        send_matrix(diag3(MINV, MAXV, MINV));
        send_matrix(diag3(32'd1, 32'd1, 32'd1));
        send_matrix(diag3(-ONE, ONE << 1, ONE >> 1));
        send_matrix({MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV});
        send_matrix({32'd7, 32'd8, 32'd10, 32'd4, 32'd5, 32'd6, 32'd1, 32'd2, 32'd3}
                    << 0);
        send_matrix({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF});
        send_matrix({32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1,
                     32'd1, 32'd0, 32'hFFFF_FFFF});
        drain();

        // threshold at zero: only an exact zero determinant is singular
        write_threshold(31'd0);
        send_matrix(diag3(32'd1, 32'd1, 32'd1));
        send_matrix('0);
        send_matrix(make_matrix(KIND_DEPENDENT));
        drain();

        // threshold so that the unit matrix sits exactly on the boundary
        write_threshold(31'd65536);
        send_matrix(diag3(ONE, ONE, ONE));
        send_matrix(diag3(ONE, ONE, ONE + 32'd1));
        send_matrix(diag3(-ONE, ONE, ONE));
        drain();

        // largest threshold, with a long receiver hold-off
        write_threshold(31'h7FFF_FFFF);
        hold_left = HOLD_CYCLES;
        random_items(20);
        send_matrix(diag3(MAXV, MAXV, MAXV));
        drain();

        // random phases: receiver idles, then sender idles, then neither but for a long receiver hold-off
        write_threshold(31'd1);
        send_idle_pct  = 20;
        recv_stall_pct = 64;
        random_items(N_RANDOM / 3);
        drain();
        write_threshold(31'($urandom_range(4096)));
        send_idle_pct  = 64;
        recv_stall_pct = 20;
        random_items(N_RANDOM / 3);
        drain();
        write_threshold(31'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        random_items(N_RANDOM / 3);
        drain();

        $display("%0d matrices sent, %0d results checked (%0d singular, %0d saturated)",
                 n_sent, board.n_results, board.n_singular, board.n_saturated);
        $display("threshold settings: reset, zero, unit boundary, largest and random");
        if (board.failures == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
